[sv/pf_pkg.sv]
// pf_pkg: shared types and constants for the trial-division factoriser
// result item layout, field widths and result limits
// no dependencies
package pf_pkg;

    localparam int FACTOR_BITS  = 31;
    localparam int EXP_BITS     = 5;
    localparam int MAX_RESULTS  = 9;
    localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);

    localparam logic [EXP_BITS-1:0] EXP_MAX = EXP_BITS'(31);

    typedef struct packed {
        logic [FACTOR_BITS-1:0] factor;
        logic [EXP_BITS-1:0]    exponent;
        logic                   last;
    } t_pf_res;

endpackage

[sv/pf_front.sv]
// pf_front: input stage, takes items and classifies them as empty or to be factored
// feeds pf_queue; uses pf_pkg
module pf_front
    import pf_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [31:0]           i_number,
    input  logic                  i_full,
    output logic                  o_push,
    output logic                  o_empty,
    output logic [VALUE_BITS-1:0] o_value
);

    localparam int EXT_BITS = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    logic [EXT_BITS-1:0]   w_ext;
    logic [VALUE_BITS-1:0] w_val;
    logic                  w_empty;
    logic                  r_valid;
    logic                  r_empty;
    logic [VALUE_BITS-1:0] r_value;

    // bits above the value width are ignored
    assign w_ext   = EXT_BITS'($signed(i_number));
    assign w_val   = w_ext[VALUE_BITS-1:0];
    assign w_empty = w_val[VALUE_BITS-1] || (w_val <= VALUE_BITS'(1));

    assign o_push     = r_valid && !i_full;
    assign o_in_stall = r_valid && i_full;
    assign o_empty    = r_empty;
    assign o_value    = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_empty <= w_empty;
            r_value <= w_val;
        end
    end

endmodule

[sv/pf_queue.sv]
// pf_queue: short first-in first-out queue between front and back
// flip-flop storage; no dependencies
module pf_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [CNT_BITS-1:0] r_cnt;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_cnt == CNT_BITS'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr + PTR_BITS'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd + PTR_BITS'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[sv/pf_div.sv]
// pf_div: restoring divider, one quotient bit per cycle
// gives quotient and remainder; no dependencies
module pf_div #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [VALUE_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [VALUE_BITS-1:0] o_remainder
);

    localparam int CW = $clog2(VALUE_BITS);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [VALUE_BITS-1:0] r_quo;
    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_dvs;
    logic [VALUE_BITS:0]   w_part;
    logic [VALUE_BITS:0]   w_diff;
    logic                  w_ge;

    assign w_part = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_diff = w_part - {1'b0, r_dvs};
    assign w_ge   = !w_diff[VALUE_BITS];

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[VALUE_BITS-1:0] : w_part[VALUE_BITS-1:0];
            r_quo <= {r_quo[VALUE_BITS-2:0], w_ge};
        end
    end

endmodule

[sv/pf_back.sv]
// pf_back: trial-division sequencer, drives pf_div and the output register
// takes jobs from pf_queue; uses pf_pkg and pf_div
module pf_back
    import pf_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic                  i_q_empty,
    input  logic [VALUE_BITS-1:0] i_q_value,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_pf_res               o_res
);

    localparam int EXT_BITS = (VALUE_BITS > FACTOR_BITS) ? VALUE_BITS : FACTOR_BITS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [VALUE_BITS-1:0]   r_rem, n_rem;
    logic [VALUE_BITS-1:0]   r_d, n_d;
    logic [EXP_BITS-1:0]     r_cnt, n_cnt;
    logic [RES_CNT_BITS-1:0] r_n, n_n;
    logic                    r_outer, n_outer;
    t_pf_res                 r_pend, n_pend;
    logic                    r_out_valid;
    t_pf_res                 r_out;

    logic                    w_div_start;
    logic                    w_div_done;
    logic [VALUE_BITS-1:0]   w_quo;
    logic [VALUE_BITS-1:0]   w_rmd;
    logic [VALUE_BITS-1:0]   w_d_next;
    logic [EXT_BITS-1:0]     w_d_ext;
    logic [EXT_BITS-1:0]     w_rem_ext;
    logic                    w_last_fac;
    logic                    w_slot_free;

    pf_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_rem),
        .i_divisor   (r_d),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rmd)
    );

    assign w_div_start = (r_state == S_START);
    assign w_d_next    = (r_d == VALUE_BITS'(2)) ? VALUE_BITS'(3) : r_d + VALUE_BITS'(2);
    assign w_d_ext     = EXT_BITS'(r_d);
    assign w_rem_ext   = EXT_BITS'(r_rem);
    // a remainder above one yields at least one more item, unless this item reaches the result limit
    assign w_last_fac  = (r_rem == VALUE_BITS'(1))
                      || (r_n == RES_CNT_BITS'(MAX_RESULTS - 1));
    assign w_slot_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_d     = r_d;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_outer = r_outer;
        n_pend  = r_pend;
        o_q_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_rem   = i_q_value;
                    n_d     = VALUE_BITS'(2);
                    n_cnt   = '0;
                    n_n     = '0;
                    n_outer = 1'b1;
                    if (i_q_empty) begin
                        n_pend.factor   = '0;
                        n_pend.exponent = '0;
                        n_pend.last     = 1'b1;
                        n_state         = S_EMIT;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    priority if (r_outer && (w_quo < r_d)) begin
                        // search over, what is left is prime
                        n_pend.factor   = w_rem_ext[FACTOR_BITS-1:0];
                        n_pend.exponent = EXP_BITS'(1);
                        n_pend.last     = 1'b1;
                        n_state         = S_EMIT;
                    end else if (w_rmd == '0) begin
                        n_rem   = w_quo;
                        n_cnt   = (r_cnt == EXP_MAX) ? r_cnt : r_cnt + EXP_BITS'(1);
                        n_outer = 1'b0;
                        n_state = S_START;
                    end else if (r_cnt != '0) begin
                        n_pend.factor   = w_d_ext[FACTOR_BITS-1:0];
                        n_pend.exponent = r_cnt;
                        n_pend.last     = w_last_fac;
                        n_n             = r_n + RES_CNT_BITS'(1);
                        n_d             = w_d_next;
                        n_cnt           = '0;
                        n_outer         = 1'b1;
                        n_state         = S_EMIT;
                    end else begin
                        n_d     = w_d_next;
                        n_outer = 1'b1;
                        n_state = S_START;
                    end
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_state = r_pend.last ? S_IDLE : S_START;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_n     <= '0;
            r_outer <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_outer <= n_outer;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_d    <= n_d;
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_slot_free) begin
            r_out <= r_pend;
        end
    end

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.exponent == '0)) |-> (r_out.last && (r_out.factor == '0)))
        else $error("empty item without last mark");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside division state");

    a_cand_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_d[0] || (r_d == VALUE_BITS'(2))))
        else $error("even candidate other than two");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= RES_CNT_BITS'(MAX_RESULTS))
        else $error("result count above limit");

endmodule

[sv/prime_factorizer.sv]
// prime_factorizer: trial-division factoriser, one prime and multiplicity per output item
// work: one trial division per candidate, plus one per repeated factor
// throughput: one item in factorisation at a time, up to three more waiting,
// one in the input register and two in the queue
// reset: synchronous active-low, clears the input register, queue, sequencer and output valid
module prime_factorizer
    import pf_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [31:0]            i_number,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [FACTOR_BITS-1:0] o_factor,
    output logic [EXP_BITS-1:0]    o_exponent,
    output logic                   o_last
);

    logic                  w_push;
    logic                  w_full;
    logic                  w_f_empty;
    logic [VALUE_BITS-1:0] w_f_value;
    logic                  w_q_valid;
    logic [VALUE_BITS:0]   w_q_data;
    logic                  w_q_pop;
    t_pf_res               w_res;

    pf_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_number   (i_number),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_empty    (w_f_empty),
        .o_value    (w_f_value)
    );

    pf_queue #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_empty, w_f_value}),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_q_pop)
    );

    pf_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_empty   (w_q_data[VALUE_BITS]),
        .i_q_value   (w_q_data[VALUE_BITS-1:0]),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (w_res)
    );

    assign o_factor   = w_res.factor;
    assign o_exponent = w_res.exponent;
    assign o_last     = w_res.last;

endmodule
